// ===== design/efwa_pkg.sv =====
`default_nettype none
package efwa_pkg;

	localparam int DEF_DEPTH     = 5;
	localparam int DEF_YEAR_BITS = 12;
	localparam int DEF_TAG_BITS  = 16;
	localparam int OCC_BITS      = 3;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef struct packed {
		logic upd;
		logic kind;
	} store_cmd_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_READ   = 5'b00010,
		S_UPD    = 5'b00100,
		S_DSTART = 5'b01000,
		S_DWAIT  = 5'b10000
	} ctl_state_t;

endpackage
`default_nettype wire

// ===== design/efwa_div.sv =====
`default_nettype none
module efwa_div
	import efwa_pkg::*;
#(
	parameter int SUM_W = 15,
	parameter int CNT_W = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [SUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0] divisor,
	output logic                  done,
	output logic [SUM_W-1:0]      quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  num_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;

	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;
	logic           ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			num_q <= {num_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule
`default_nettype wire

// ===== design/efwa_store.sv =====
`default_nettype none
module efwa_store
	import efwa_pkg::*;
#(
	parameter int DEPTH     = DEF_DEPTH,
	parameter int YEAR_BITS = DEF_YEAR_BITS,
	parameter int TAG_BITS  = DEF_TAG_BITS,
	parameter int CNT_W     = $clog2(DEPTH + 1),
	parameter int SUM_W     = YEAR_BITS + CNT_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire store_cmd_t           cmd,
	input  wire logic [TAG_BITS-1:0]  tag,
	input  wire logic [YEAR_BITS-1:0] year,
	output logic [TAG_BITS-1:0]       rd_tag,
	output logic [YEAR_BITS-1:0]      rd_year,
	output logic [CNT_W-1:0]          count,
	output logic [SUM_W-1:0]          sum
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W = CNT_W + 1;
	localparam int ENT_W = TAG_BITS + YEAR_BITS;

	logic [ENT_W-1:0] mem_q [DEPTH];
	logic [ENT_W-1:0] rd_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;

	logic             full;
	logic             empty;
	logic [PTR_W-1:0] head_inc;
	logic [IDX_W-1:0] tail_raw;
	logic [PTR_W-1:0] tail;
	logic [SUM_W-1:0] old_year;
	logic [SUM_W-1:0] new_year;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_raw = IDX_W'(head_q) + IDX_W'(count_q);
	assign old_year = SUM_W'(rd_q[YEAR_BITS-1:0]);
	assign new_year = SUM_W'(year);

	// a full queue writes over its oldest slot
	always_comb begin
		if (full) begin
			tail = head_q;
		end else if (tail_raw >= IDX_W'(DEPTH)) begin
			tail = PTR_W'(tail_raw - IDX_W'(DEPTH));
		end else begin
			tail = PTR_W'(tail_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (cmd.upd) begin
			if (cmd.kind == KIND_INSERT) begin
				if (full) begin
					head_q <= head_inc;
					sum_q  <= sum_q - old_year + new_year;
				end else begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_q + new_year;
				end
			end else if (!empty) begin
				head_q  <= head_inc;
				count_q <= count_q - 1'b1;
				sum_q   <= sum_q - old_year;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && cmd.kind == KIND_INSERT) begin
			mem_q[tail] <= {tag, year};
		end
		rd_q <= mem_q[head_q];
	end

	assign rd_tag  = rd_q[ENT_W-1:YEAR_BITS];
	assign rd_year = rd_q[YEAR_BITS-1:0];
	assign count   = count_q;
	assign sum     = sum_q;

endmodule
`default_nettype wire

// ===== design/evicting_fifo_window_average_top.sv =====
// Insert: start passes through READ, UPD and DSTART, then waits in DWAIT on the bit-serial
// divider that yields one quotient bit per cycle; the result strobe follows its done.
// Remove: the result strobe follows READ and UPD. One transaction at a time; busy is high
// until the result is shown, and start may be taken in the cycle of the strobe.
// Results cannot be stalled. arst_n clears the queue pointers, count and sum; the
// entry store itself is not cleared.
`default_nettype none
module evicting_fifo_window_average_top
	import efwa_pkg::*;
#(
	parameter int DEPTH     = DEF_DEPTH,
	parameter int YEAR_BITS = DEF_YEAR_BITS,
	parameter int TAG_BITS  = DEF_TAG_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 kind,
	input  wire logic [TAG_BITS-1:0]  record_tag,
	input  wire logic [YEAR_BITS-1:0] year_value,
	output logic                      done,
	output logic [YEAR_BITS-1:0]      average_year,
	output logic [TAG_BITS-1:0]       removed_tag,
	output logic [YEAR_BITS-1:0]      removed_year,
	output logic                      empty_error,
	output logic [OCC_BITS-1:0]       occupancy
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = YEAR_BITS + CNT_W;

	ctl_state_t state_q;

	logic                 kind_q;
	logic [TAG_BITS-1:0]  tag_q;
	logic [YEAR_BITS-1:0] year_q;

	logic                 done_q;
	logic [YEAR_BITS-1:0] avg_q;
	logic [TAG_BITS-1:0]  rtag_q;
	logic [YEAR_BITS-1:0] ryear_q;
	logic                 err_q;
	logic [OCC_BITS-1:0]  occ_q;

	store_cmd_t           cmd;
	logic [TAG_BITS-1:0]  rd_tag;
	logic [YEAR_BITS-1:0] rd_year;
	logic [CNT_W-1:0]     count;
	logic [SUM_W-1:0]     sum;
	logic                 div_go;
	logic                 div_done;
	logic [SUM_W-1:0]     quotient;
	logic                 accept;

	assign busy     = state_q != S_IDLE;
	assign accept   = start && !busy;
	assign cmd.upd  = state_q == S_UPD;
	assign cmd.kind = kind_q;
	assign div_go   = state_q == S_DSTART;

	efwa_store #(
		.DEPTH     (DEPTH),
		.YEAR_BITS (YEAR_BITS),
		.TAG_BITS  (TAG_BITS),
		.CNT_W     (CNT_W),
		.SUM_W     (SUM_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.tag     (tag_q),
		.year    (year_q),
		.rd_tag  (rd_tag),
		.rd_year (rd_year),
		.count   (count),
		.sum     (sum)
	);

	efwa_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (sum),
		.divisor  (count),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (kind_q == KIND_INSERT) begin
						state_q <= S_DSTART;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DSTART: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			tag_q  <= record_tag;
			year_q <= year_value;
		end
		if (state_q == S_UPD && kind_q == KIND_REMOVE) begin
			avg_q <= '0;
			if (count == '0) begin
				rtag_q  <= '0;
				ryear_q <= '0;
				err_q   <= 1'b1;
				occ_q   <= '0;
			end else begin
				rtag_q  <= rd_tag;
				ryear_q <= rd_year;
				err_q   <= 1'b0;
				occ_q   <= OCC_BITS'(count - 1'b1);
			end
		end else if (state_q == S_DWAIT && div_done) begin
			avg_q   <= YEAR_BITS'(quotient);
			rtag_q  <= '0;
			ryear_q <= '0;
			err_q   <= 1'b0;
			occ_q   <= OCC_BITS'(count);
		end
	end

	assign done         = done_q;
	assign average_year = avg_q;
	assign removed_tag  = rtag_q;
	assign removed_year = ryear_q;
	assign empty_error  = err_q;
	assign occupancy    = occ_q;

endmodule
`default_nettype wire
